@@ rtl/tpp_pkg.sv @@
// Shared types, constants and codes of the tile pixel placer.
package tpp_pkg;

  // Size registers saturate to 1..MAX_DIM
  localparam int MAX_DIM   = 8192;
  localparam int DIM_W     = 14;
  localparam int POS_W     = 13;
  localparam int TILE_W    = 26;
  localparam int BYTE_W    = 8;
  localparam int CHAN_W    = 2;
  localparam int ADDR_W    = 28;
  localparam int PLANE_W   = 27;
  localparam int MAC_W     = TILE_W + DIM_W;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_TILES_ACROSS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_X     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_Y     = 3'd6;

  // Color channel codes
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [TILE_W-1:0] tile_number;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] plane_address;
    logic [BYTE_W-1:0] pixel_byte;
    logic [CHAN_W-1:0] channel;
    logic              last;
  } out_item_t;

  // Register values as the datapath uses them (sizes already saturated)
  typedef struct packed {
    logic [DIM_W-1:0] tiles_across;
    logic [DIM_W-1:0] tile_width;
    logic [DIM_W-1:0] tile_height;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [POS_W-1:0] window_x;
    logic [POS_W-1:0] window_y;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FX,
    S_FY,
    S_PLANE,
    S_CHECK,
    S_BASE,
    S_EMIT
  } tpp_state_t;

endpackage

@@ rtl/tpp_cfg_regs.sv @@
// APB register file holding the frame, tile and window geometry.
module tpp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpp_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output tpp_pkg::cfg_t                cfg
);
  import tpp_pkg::*;

  logic [DIM_W-1:0]     across_r, tw_r, th_r, iw_r, ih_r;
  logic [POS_W-1:0]     wx_r, wy_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    return res;
  endfunction

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      across_r <= DIM_W'(1);
      tw_r     <= DIM_W'(1);
      th_r     <= DIM_W'(1);
      iw_r     <= DIM_W'(1);
      ih_r     <= DIM_W'(1);
      wx_r     <= '0;
      wy_r     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TILES_ACROSS: across_r <= pwdata[DIM_W-1:0];
        REG_TILE_WIDTH:   tw_r     <= pwdata[DIM_W-1:0];
        REG_TILE_HEIGHT:  th_r     <= pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:  iw_r     <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: ih_r     <= pwdata[DIM_W-1:0];
        REG_WINDOW_X:     wx_r     <= pwdata[POS_W-1:0];
        REG_WINDOW_Y:     wy_r     <= pwdata[POS_W-1:0];
        default:          ;
      endcase
    end
  end

  // Return the stored value on read
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TILES_ACROSS: prdata = PDATA_W'(across_r);
      REG_TILE_WIDTH:   prdata = PDATA_W'(tw_r);
      REG_TILE_HEIGHT:  prdata = PDATA_W'(th_r);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(iw_r);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(ih_r);
      REG_WINDOW_X:     prdata = PDATA_W'(wx_r);
      REG_WINDOW_Y:     prdata = PDATA_W'(wy_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp size registers into their legal range
  always_comb begin
    cfg.tiles_across = sat_dim(across_r);
    cfg.tile_width   = sat_dim(tw_r);
    cfg.tile_height  = sat_dim(th_r);
    cfg.image_width  = sat_dim(iw_r);
    cfg.image_height = sat_dim(ih_r);
    cfg.window_x     = wx_r;
    cfg.window_y     = wy_r;
  end

endmodule

@@ rtl/tpp_div.sv @@
// Radix-2 restoring divider splitting a tile number into tile row and column.
module tpp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tpp_pkg::TILE_W-1:0]  dividend,
  input  logic [tpp_pkg::DIM_W-1:0]   divisor,
  output logic                        done,
  output logic [tpp_pkg::TILE_W-1:0]  quotient,
  output logic [tpp_pkg::DIM_W-1:0]   remainder
);
  import tpp_pkg::*;

  localparam int CNT_W = $clog2(TILE_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TILE_W-1:0]  quo_r, quo_nxt;
  logic [DIM_W-1:0]   rem_r, rem_nxt;
  logic [DIM_W-1:0]   dvs_r, dvs_nxt;
  logic [DIM_W:0]     trial;
  logic               ge;

  // One quotient bit per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[TILE_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[TILE_W-2:0], ge};
      rem_nxt = ge ? DIM_W'(trial - {1'b0, dvs_r}) : trial[DIM_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TILE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/tpp_mac.sv @@
// Shared multiply-add unit with a registered result: p = a * b + c.
module tpp_mac (
  input  logic                        clk,
  input  logic [tpp_pkg::TILE_W-1:0]  a,
  input  logic [tpp_pkg::DIM_W-1:0]   b,
  input  logic [tpp_pkg::POS_W-1:0]   c,
  output logic [tpp_pkg::MAC_W-1:0]   p
);
  import tpp_pkg::*;

  logic [MAC_W-1:0] p_r, p_nxt;

  // Product plus offset, fits in MAC_W for all operand values
  assign p_nxt = (MAC_W'(a) * MAC_W'(b)) + MAC_W'(c);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

@@ rtl/tile_pixel_placer_unit.sv @@
// Each accepted pixel goes through the 26-step tile-number divider and up to four
// passes through the shared multiply-add unit (three when the pixel is dropped);
// no new pixel is taken until the last one is through. Three writes per kept
// pixel, one per cycle while out_ready is high.
// Reset (rst_n, synchronous, active low): sizes to 1, window offset to 0,
// in-tile counters to 0, sequencer idle.
module tile_pixel_placer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tpp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tpp_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpp_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tpp_pkg::*;

  cfg_t              cfg;
  tpp_state_t        state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  out_item_t         out_r, out_nxt;
  logic [MAC_W-1:0]  fx_r, fx_nxt, fy_r, fy_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [POS_W-1:0]  cit_r, cit_nxt, rit_r, rit_nxt;

  logic              div_start, div_done;
  logic [TILE_W-1:0] div_quo;
  logic [DIM_W-1:0]  div_rem;
  logic [TILE_W-1:0] mac_a;
  logic [DIM_W-1:0]  mac_b;
  logic [POS_W-1:0]  mac_c;
  logic [MAC_W-1:0]  mac_p;

  logic [POS_W-1:0]  col_eff, row_eff, col_adv, row_adv;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [MAC_W-1:0]  dx, dy;
  logic              in_win;

  tpp_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (item_nxt.tile_number),
    .divisor   (cfg.tiles_across),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  tpp_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .p   (mac_p)
  );

  // Take counters beyond the tile as zero, then advance with wrap
  always_comb begin
    col_eff = ({1'b0, cit_r} >= cfg.tile_width)  ? '0 : cit_r;
    row_eff = ({1'b0, rit_r} >= cfg.tile_height) ? '0 : rit_r;
    col_inc = {1'b0, col_eff} + DIM_W'(1);
    row_inc = {1'b0, row_eff} + DIM_W'(1);
    if (col_inc >= cfg.tile_width) begin
      col_adv = '0;
      row_adv = (row_inc >= cfg.tile_height) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_adv = col_inc[POS_W-1:0];
      row_adv = row_eff;
    end
  end

  // Window-relative position and bounds check
  always_comb begin
    dx     = fx_r - MAC_W'(cfg.window_x);
    dy     = fy_r - MAC_W'(cfg.window_y);
    in_win = (fx_r >= MAC_W'(cfg.window_x)) && (fy_r >= MAC_W'(cfg.window_y)) &&
             (dx < MAC_W'(cfg.image_width)) && (dy < MAC_W'(cfg.image_height));
  end

  // Sequence divider, multiply-add passes and the three writes
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    out_nxt   = out_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    plane_nxt = plane_r;
    cit_nxt   = cit_r;
    rit_nxt   = rit_r;
    div_start = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    mac_c     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FX;
      end
      S_FX: begin
        // frame x = tile column * tile width + column in tile
        mac_a     = TILE_W'(div_rem);
        mac_b     = cfg.tile_width;
        mac_c     = col_eff;
        state_nxt = S_FY;
      end
      S_FY: begin
        fx_nxt    = mac_p;
        mac_a     = div_quo;
        mac_b     = cfg.tile_height;
        mac_c     = row_eff;
        state_nxt = S_PLANE;
      end
      S_PLANE: begin
        fy_nxt    = mac_p;
        mac_a     = TILE_W'(cfg.image_width);
        mac_b     = cfg.image_height;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        plane_nxt = mac_p[PLANE_W-1:0];
        if (in_win) begin
          mac_a     = TILE_W'(dy[POS_W-1:0]);
          mac_b     = cfg.image_width;
          mac_c     = dx[POS_W-1:0];
          state_nxt = S_BASE;
        end else begin
          // drop the pixel, still advance the tile counters
          cit_nxt   = col_adv;
          rit_nxt   = row_adv;
          state_nxt = S_IDLE;
        end
      end
      S_BASE: begin
        out_nxt.plane_address = mac_p[ADDR_W-1:0];
        out_nxt.pixel_byte    = item_r.red;
        out_nxt.channel       = CH_RED;
        out_nxt.last          = 1'b0;
        state_nxt             = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (out_r.last) begin
            cit_nxt   = col_adv;
            rit_nxt   = row_adv;
            state_nxt = S_IDLE;
          end else begin
            out_nxt.plane_address = out_r.plane_address + ADDR_W'(plane_r);
            if (out_r.channel == CH_RED) begin
              out_nxt.channel    = CH_GREEN;
              out_nxt.pixel_byte = item_r.green;
              out_nxt.last       = 1'b0;
            end else begin
              out_nxt.channel    = CH_BLUE;
              out_nxt.pixel_byte = item_r.blue;
              out_nxt.last       = 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cit_r <= '0;
      rit_r <= '0;
    end else begin
      cit_r <= cit_nxt;
      rit_r <= rit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    out_r   <= out_nxt;
    fx_r    <= fx_nxt;
    fy_r    <= fy_nxt;
    plane_r <= plane_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_data  = out_r;

  // Never take a pixel while a write is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a write is pending");

  // An accepted pixel starts the divider
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DIV))
    else $error("accepted pixel did not start the divider");

  // Red write is followed by green
  a_red_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.channel == CH_RED) |=>
      (out_valid && out_data.channel == CH_GREEN))
    else $error("green write missing after red");

  // Green write is followed by blue, which closes the run
  a_green_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.channel == CH_GREEN) |=>
      (out_valid && out_data.channel == CH_BLUE && out_data.last))
    else $error("blue write missing after green");

  // Only the blue write carries last
  a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.channel == CH_BLUE))
    else $error("last flag on a non-blue write");

endmodule
